>>> hdl/tmst_pkg.sv
// tmst_pkg: shared types and codes for the tagged message slot table.
// No dependencies.
`default_nettype none
package tmst_pkg;

	localparam int SLOT_NUM_W = 10;
	localparam int CNT_W      = 11;

	typedef enum logic [2:0] {
		MODE_WRITE_NEW   = 3'd0,
		MODE_WRITE_REPLY = 3'd1,
		MODE_READ_TYPE   = 3'd2,
		MODE_READ_INDEX  = 3'd3,
		MODE_READ_FIRST  = 3'd4,
		MODE_READ_REPLY  = 3'd5,
		MODE_TICK        = 3'd6,
		MODE_SWEEP       = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_ARG   = 3'd1,
		ST_TOO_LONG  = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_BUF_SMALL = 3'd4
	} status_t;

	localparam logic [2:0] REG_SLOTS_IN_USE = 3'd0;
	localparam logic [2:0] REG_MAX_LENGTH   = 3'd1;
	localparam logic [2:0] REG_MIN_INDEX    = 3'd2;
	localparam logic [2:0] REG_MAX_INDEX    = 3'd3;
	localparam logic [2:0] REG_MAX_STAY     = 3'd4;

	// request token that walks down the row of slot cells
	typedef struct packed {
		logic                  valid;
		logic                  done;
		mode_t                 mode;
		logic [30:0]           ty;
		logic [30:0]           ix;
		logic [21:0]           pv;
		logic [21:0]           caller;
		logic [15:0]           len;
		logic [15:0]           cap;
		logic [63:0]           pay;
		logic [31:0]           now;
		logic [30:0]           cand;
		status_t               status;
		logic [SLOT_NUM_W-1:0] slot;
		logic [30:0]           o_type;
		logic [30:0]           o_index;
		logic [21:0]           o_prov;
		logic [21:0]           o_dealer;
		logic [15:0]           o_len;
		logic [63:0]           o_pay;
		logic [CNT_W-1:0]      cnt;
	} token_t;

endpackage
`default_nettype wire

>>> hdl/tmst_cell.sv
// tmst_cell: one message slot and its share of the scan.
// Depends on tmst_pkg.
`default_nettype none
module tmst_cell #(
	parameter int CELL = 0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [6:0]      slots_in_use,
	input  wire logic [31:0]     max_stay,
	input  tmst_pkg::token_t     tok_in,
	output tmst_pkg::token_t     tok_out
);

	logic [30:0] type_q;
	logic [30:0] index_q;
	logic [21:0] prov_q;
	logic [21:0] dealer_q;
	logic [15:0] len_q;
	logic [63:0] pay_q;
	logic [31:0] stamp_q;
	tmst_pkg::token_t tok_q;

	tmst_pkg::token_t nt;
	logic        in_rng, occ, act, match, we, ce, is_new;
	logic [30:0] new_index;
	logic [21:0] new_prov, new_dealer;

	assign in_rng     = tmst_pkg::CNT_W'(slots_in_use) > tmst_pkg::CNT_W'(CELL);
	assign occ        = type_q != '0;
	assign act        = tok_in.valid && !tok_in.done && in_rng;
	assign is_new     = tok_in.mode == tmst_pkg::MODE_WRITE_NEW;
	assign new_index  = is_new ? tok_in.cand : tok_in.ix;
	assign new_prov   = is_new ? tok_in.caller : tok_in.pv;
	assign new_dealer = is_new ? 22'd0 : tok_in.caller;

	always_comb begin
		unique case (tok_in.mode)
			tmst_pkg::MODE_READ_TYPE:  match = occ && type_q == tok_in.ty && dealer_q == '0;
			tmst_pkg::MODE_READ_INDEX: match = occ && index_q == tok_in.ix && dealer_q != '0;
			tmst_pkg::MODE_READ_FIRST: match = occ && dealer_q == '0;
			tmst_pkg::MODE_READ_REPLY: match = occ && dealer_q != '0 && index_q == tok_in.ix
				&& prov_q == tok_in.pv;
			default:                   match = 1'b0;
		endcase
	end

	always_comb begin
		nt = tok_in;
		we = 1'b0;
		ce = 1'b0;
		if (act) begin
			unique case (tok_in.mode)
				tmst_pkg::MODE_WRITE_NEW, tmst_pkg::MODE_WRITE_REPLY: begin
					if (!occ) begin
						we          = 1'b1;
						nt.done     = 1'b1;
						nt.status   = tmst_pkg::ST_OK;
						nt.slot     = tmst_pkg::SLOT_NUM_W'(CELL);
						nt.o_type   = tok_in.ty;
						nt.o_index  = new_index;
						nt.o_prov   = new_prov;
						nt.o_dealer = new_dealer;
						nt.o_len    = tok_in.len;
					end
				end
				tmst_pkg::MODE_READ_TYPE, tmst_pkg::MODE_READ_INDEX,
				tmst_pkg::MODE_READ_FIRST, tmst_pkg::MODE_READ_REPLY: begin
					if (match) begin
						nt.done = 1'b1;
						nt.slot = tmst_pkg::SLOT_NUM_W'(CELL);
						if (len_q > tok_in.cap) begin
							nt.status = tmst_pkg::ST_BUF_SMALL;
						end else begin
							ce          = 1'b1;
							nt.status   = tmst_pkg::ST_OK;
							nt.o_type   = type_q;
							nt.o_index  = index_q;
							nt.o_prov   = prov_q;
							nt.o_dealer = dealer_q;
							nt.o_len    = len_q;
							nt.o_pay    = pay_q;
						end
					end
				end
				tmst_pkg::MODE_SWEEP: begin
					if (occ && (tok_in.now - stamp_q) >= max_stay) begin
						ce     = 1'b1;
						nt.cnt = tok_in.cnt + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q <= '0;
			tok_q  <= '0;
		end else begin
			tok_q <= nt;
			if (we) begin
				type_q <= tok_in.ty;
			end else if (ce) begin
				type_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			index_q  <= new_index;
			prov_q   <= new_prov;
			dealer_q <= new_dealer;
			len_q    <= tok_in.len;
			pay_q    <= tok_in.pay;
			stamp_q  <= tok_in.now;
		end
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

>>> hdl/tagged_message_slot_table.sv
// Request/reply mailbox over a row of SLOTS message slot cells. Each request
// walks the row one cell per clock, then passes through a result register to
// the output registers; one request is in flight at a time, and a tick or
// a rejected argument takes the same path. Depends on tmst_pkg, tmst_cell.
`default_nettype none
module tagged_message_slot_table #(
	parameter int SLOTS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  mode,
	input  wire logic [30:0] msg_type,
	input  wire logic [30:0] seq_index,
	input  wire logic [21:0] provider_id,
	input  wire logic [21:0] caller_id,
	input  wire logic [15:0] length,
	input  wire logic [15:0] capacity,
	input  wire logic [63:0] payload,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [5:0]       slot,
	output logic [30:0]      out_type,
	output logic [30:0]      out_index,
	output logic [21:0]      out_provider,
	output logic [21:0]      out_dealer,
	output logic [15:0]      out_length,
	output logic [63:0]      out_payload,
	output logic [6:0]       freed_count
);

	logic [6:0]  slots_in_use_q;
	logic [15:0] max_length_q;
	logic [30:0] min_index_q, max_index_q, next_q;
	logic [31:0] max_stay_q, now_q;
	logic        busy_q, res_v_q, out_valid_q;
	tmst_pkg::token_t launch_q, res_q, lt;
	tmst_pkg::token_t chain [SLOTS+1];
	tmst_pkg::mode_t  md;
	logic        accept, is_wr, is_rd;

	assign chain[0] = launch_q;

	genvar gi;
	generate
		for (gi = 0; gi < SLOTS; gi++) begin : g_cell
			tmst_cell #(.CELL(gi)) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.slots_in_use (slots_in_use_q),
				.max_stay     (max_stay_q),
				.tok_in       (chain[gi]),
				.tok_out      (chain[gi+1])
			);
		end
	endgenerate

	assign in_stall = busy_q;
	assign accept   = in_valid && !busy_q;
	assign md       = tmst_pkg::mode_t'(mode);
	assign is_wr    = md == tmst_pkg::MODE_WRITE_NEW || md == tmst_pkg::MODE_WRITE_REPLY;
	assign is_rd    = md == tmst_pkg::MODE_READ_TYPE || md == tmst_pkg::MODE_READ_INDEX
		|| md == tmst_pkg::MODE_READ_FIRST || md == tmst_pkg::MODE_READ_REPLY;

	always_comb begin
		lt        = '0;
		lt.valid  = 1'b1;
		lt.mode   = md;
		lt.ty     = msg_type;
		lt.ix     = seq_index;
		lt.pv     = provider_id;
		lt.caller = caller_id;
		lt.len    = length;
		lt.cap    = capacity;
		lt.pay    = payload;
		lt.now    = now_q;
		lt.cand   = (next_q == '0 || next_q >= max_index_q) ? min_index_q : next_q;
		lt.status = (is_wr || is_rd) ? tmst_pkg::ST_NOT_FOUND : tmst_pkg::ST_OK;
		if (is_wr) begin
			if (length > max_length_q) begin
				lt.status = tmst_pkg::ST_TOO_LONG;
				lt.done   = 1'b1;
			end else if (msg_type == '0
				|| (md == tmst_pkg::MODE_WRITE_REPLY && caller_id == '0)) begin
				lt.status = tmst_pkg::ST_BAD_ARG;
				lt.done   = 1'b1;
			end
		end else if (is_rd) begin
			if ((md == tmst_pkg::MODE_READ_TYPE && msg_type == '0)
				|| ((md == tmst_pkg::MODE_READ_INDEX || md == tmst_pkg::MODE_READ_REPLY)
				&& seq_index == '0)) begin
				lt.status = tmst_pkg::ST_BAD_ARG;
				lt.done   = 1'b1;
			end
		end else if (md == tmst_pkg::MODE_TICK) begin
			lt.done = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_in_use_q <= 7'd64;
			max_length_q   <= 16'd8192;
			min_index_q    <= 31'd1;
			max_index_q    <= 31'd99999999;
			max_stay_q     <= 32'd60;
			next_q         <= '0;
			now_q          <= '0;
			busy_q         <= 1'b0;
			res_v_q        <= 1'b0;
			out_valid_q    <= 1'b0;
			launch_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tmst_pkg::REG_SLOTS_IN_USE: slots_in_use_q <= cfg_data[6:0];
					tmst_pkg::REG_MAX_LENGTH:   max_length_q   <= cfg_data[15:0];
					tmst_pkg::REG_MIN_INDEX:    min_index_q    <= cfg_data[30:0];
					tmst_pkg::REG_MAX_INDEX:    max_index_q    <= cfg_data[30:0];
					tmst_pkg::REG_MAX_STAY:     max_stay_q     <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				launch_q <= lt;
				busy_q   <= 1'b1;
				if (md == tmst_pkg::MODE_TICK) begin
					now_q <= now_q + 32'd1;
				end
			end else begin
				launch_q.valid <= 1'b0;
			end
			if (chain[SLOTS].valid) begin
				res_v_q <= 1'b1;
				if (chain[SLOTS].mode == tmst_pkg::MODE_WRITE_NEW
					&& chain[SLOTS].status == tmst_pkg::ST_OK) begin
					next_q <= chain[SLOTS].cand + 31'd1;
				end
			end
			if (res_v_q && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
				res_v_q     <= 1'b0;
				busy_q      <= 1'b0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chain[SLOTS].valid) begin
			res_q <= chain[SLOTS];
		end
		if (res_v_q && (!out_valid_q || !out_stall)) begin
			status       <= res_q.status;
			slot         <= res_q.slot[5:0];
			out_type     <= res_q.o_type;
			out_index    <= res_q.o_index;
			out_provider <= res_q.o_prov;
			out_dealer   <= res_q.o_dealer;
			out_length   <= res_q.o_len;
			out_payload  <= res_q.o_pay;
			freed_count  <= res_q.cnt[6:0];
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire
